[rtl/bet_pkg.sv]
// Shared types and constants for the Bezier easing table block.
// No dependencies.
package bet_pkg;

  localparam int unsigned QW = 17;          // Q1.16 unsigned width
  localparam int unsigned PW = QW + 1;      // scaled control point width, up to 3.0
  localparam logic [QW-1:0] ONE_Q16 = 17'd65536;
  localparam int unsigned SOLVE_STEPS = 32;
  localparam int unsigned SOLVE_TOL = 6;

  // configuration register indexes
  localparam logic [1:0] REG_X1 = 2'd0;
  localparam logic [1:0] REG_Y1 = 2'd1;
  localparam logic [1:0] REG_X2 = 2'd2;
  localparam logic [1:0] REG_Y2 = 2'd3;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_PTS,   // scale control points
    OP_SOLVE_INIT, // t = target of current entry
    OP_CURVE_X,    // start curve evaluation at t with x points
    OP_CURVE_Y,    // start curve evaluation at t with y points
    OP_STEP,       // apply damped step from error
    OP_WRITE_Y,    // store saturated y into table entry
    OP_WRITE_ENDS, // store entry 0 or last entry
    OP_EVAL_RD0,   // read first neighbour
    OP_EVAL_RD1,   // read second neighbour
    OP_EVAL_MUL    // interpolate
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [10:0] idx;     // table entry under work
    logic        last_end;
  } dp_cmd_t;

  typedef struct packed {
    logic curve_done;
    logic converged;
  } dp_stat_t;

  // c*3/127 in Q.16, rounded: (c*196608+63)/127.
  // 196608 = 127*1548 + 12, so the quotient is 1548*c + (12*c+63)/127,
  // and the small quotient comes from a reciprocal multiply (exact below 2048).
  function automatic logic [PW-1:0] scale_point(input logic [6:0] c);
    logic [10:0] v;
    logic [23:0] q;
    v = 11'(c) * 11'd12 + 11'd63;
    q = 24'(v) * 24'd8257;
    return PW'(18'(c) * 18'd1548 + 18'(q >> 20));
  endfunction

endpackage

[rtl/bet_ctrl.sv]
// Controller for the Bezier easing table: sequences rebuilds and evaluations.
// Depends on bet_pkg.
module bet_ctrl #(
  parameter int unsigned DIV = 256,
  parameter int unsigned IW = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             kind,
  input  logic             is_linear_pts,
  input  bet_pkg::dp_stat_t stat,
  output logic             busy,
  output logic             set_linear,
  output logic             clr_linear,
  output logic             linear_mode,
  output bet_pkg::dp_cmd_t cmd,
  output logic             strobe
);
  import bet_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PTS, S_ENDS0, S_ENDS1, S_INIT, S_CX, S_CXW, S_CHK,
    S_CY, S_CYW, S_WR, S_RD1, S_MUL, S_OUT
  } state_t;

  state_t      state;
  logic [IW-1:0] idx;
  logic [5:0]  steps;

  always_comb begin
    cmd.op = OP_NONE;
    cmd.idx = 11'(idx);
    cmd.last_end = (state == S_ENDS1);
    unique case (state)
      S_PTS:   cmd.op = OP_LOAD_PTS;
      S_ENDS0, S_ENDS1: cmd.op = OP_WRITE_ENDS;
      S_INIT:  cmd.op = OP_SOLVE_INIT;
      S_CX:    cmd.op = OP_CURVE_X;
      S_CHK:   cmd.op = (stat.converged || steps == 6'(SOLVE_STEPS)) ? OP_NONE : OP_STEP;
      S_CY:    cmd.op = OP_CURVE_Y;
      S_WR:    cmd.op = OP_WRITE_Y;
      S_RD1:   cmd.op = OP_EVAL_RD1;
      S_MUL:   cmd.op = OP_EVAL_MUL;
      default: cmd.op = OP_NONE;
    endcase
    if (state == S_IDLE && start && kind && !linear_mode) cmd.op = OP_EVAL_RD0;
  end

  assign busy = (state != S_IDLE);
  assign set_linear = (state == S_IDLE) && start && !kind && is_linear_pts;
  assign clr_linear = (state == S_WR) && (idx == IW'(DIV - 1));

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      steps <= '0;
      strobe <= 1'b0;
      linear_mode <= 1'b1;
    end else begin
      strobe <= 1'b0;
      if (set_linear) linear_mode <= 1'b1;
      if (clr_linear) linear_mode <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          if (!kind) begin
            if (!is_linear_pts) state <= S_PTS;
          end else if (linear_mode) begin
            strobe <= 1'b1;
          end else begin
            state <= S_RD1;
          end
        end
        S_PTS: state <= S_ENDS0;
        S_ENDS0: state <= S_ENDS1;
        S_ENDS1: begin idx <= IW'(1); state <= S_INIT; end
        S_INIT: begin steps <= '0; state <= S_CX; end
        S_CX: state <= S_CXW;
        S_CXW: if (stat.curve_done) state <= S_CHK;
        S_CHK: begin
          if (stat.converged || steps == 6'(SOLVE_STEPS)) state <= S_CY;
          else begin steps <= steps + 6'd1; state <= S_CX; end
        end
        S_CY: state <= S_CYW;
        S_CYW: if (stat.curve_done) state <= S_WR;
        S_WR: begin
          if (idx == IW'(DIV - 1)) state <= S_IDLE;
          else begin idx <= idx + IW'(1); state <= S_INIT; end
        end
        S_RD1: state <= S_MUL;
        S_MUL: state <= S_OUT;
        S_OUT: begin strobe <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/bet_dp.sv]
// Datapath for the Bezier easing table: curve evaluator, solver, table, interpolator.
// Depends on bet_pkg.
module bet_dp #(
  parameter int unsigned DIV = 256,
  parameter int unsigned IW = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bet_pkg::dp_cmd_t     cmd,
  input  logic [6:0]           x1,
  input  logic [6:0]           y1,
  input  logic [6:0]           x2,
  input  logic [6:0]           y2,
  input  logic [16:0]          x_in,
  input  logic                 linear_mode,
  output bet_pkg::dp_stat_t    stat,
  output logic [16:0]          y_out
);
  import bet_pkg::*;

  localparam int unsigned DEPTH = DIV + 1;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [IW-1:0] DIV_I = IW'(DIV);
  // target numerator steps by 65536 per entry; entry 1 starts at 65536 + DIV/2
  localparam int unsigned TQ0 = 65536 / DIV;
  localparam int unsigned TR0 = 65536 % DIV;
  localparam int unsigned TQ1 = (65536 + DIV / 2) / DIV;
  localparam int unsigned TR1 = (65536 + DIV / 2) % DIV;

  logic [QW-1:0] mem [DEPTH];
  logic [PW-1:0] px1, py1, px2, py2, p1s, p2s;
  logic [QW-1:0] t, target;
  logic signed [19:0] err;

  // curve evaluator: one multiply per cycle, sequenced by a micro counter
  logic [3:0]  ph;
  logic        run;
  logic [QW-1:0] u, a;
  logic [PW-1:0] b;
  logic [33:0] prod;
  logic [QW:0] m;          // rounded product
  logic [18:0] sum;

  assign prod = 34'(a) * 34'(b);
  assign m = (QW+1)'((prod + 34'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      ph <= '0;
    end else if (cmd.op == OP_CURVE_X || cmd.op == OP_CURVE_Y) begin
      run <= 1'b1;
      ph <= '0;
    end else if (run) begin
      ph <= ph + 4'd1;
      if (ph == 4'd8) run <= 1'b0;
    end
  end

  // phases: 0 uu,1 uu*t,2 *p1,3 ut,4 ut*t,5 *p2,6 tt,7 tt*t,8 done
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CURVE_X || cmd.op == OP_CURVE_Y) begin
      u <= ONE_Q16 - t;
      p1s <= (cmd.op == OP_CURVE_X) ? px1 : py1;
      p2s <= (cmd.op == OP_CURVE_X) ? px2 : py2;
      a <= ONE_Q16 - t;
      b <= {1'b0, ONE_Q16 - t};
      sum <= '0;
    end else if (run) begin
      unique case (ph)
        4'd0: begin a <= QW'(m); b <= {1'b0, t}; end
        4'd1: begin a <= QW'(m); b <= p1s; end
        4'd2: begin sum <= sum + 19'(m); a <= u; b <= {1'b0, t}; end
        4'd3: begin a <= QW'(m); b <= {1'b0, t}; end
        4'd4: begin a <= QW'(m); b <= p2s; end
        4'd5: begin sum <= sum + 19'(m); a <= t; b <= {1'b0, t}; end
        4'd6: begin a <= QW'(m); b <= {1'b0, t}; end
        4'd7: sum <= sum + 19'(m);
        default: ;
      endcase
    end
  end

  assign stat.curve_done = run && (ph == 4'd8);
  assign err = 20'(sum) - 20'(target);
  assign stat.converged = (err >= -20'sd6) && (err <= 20'sd6);

  // solver state; the per-entry target is kept as a running quotient/remainder
  logic [QW-1:0] tq;
  logic [IW-1:0] tr, tr_sum;
  logic signed [19:0] half, tn;
  assign tr_sum = tr + IW'(TR0);
  assign half = (err >= 0) ? (err >>> 1) : -((-err) >>> 1);
  assign tn = $signed({3'b0, t}) - half;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_PTS) begin
      px1 <= scale_point(x1); py1 <= scale_point(y1);
      px2 <= scale_point(x2); py2 <= scale_point(y2);
      tq <= QW'(TQ1);
      tr <= IW'(TR1);
    end
    if (cmd.op == OP_WRITE_Y) begin
      if (tr_sum >= DIV_I) begin
        tq <= tq + QW'(TQ0 + 1);
        tr <= tr_sum - DIV_I;
      end else begin
        tq <= tq + QW'(TQ0);
        tr <= tr_sum;
      end
    end
    if (cmd.op == OP_SOLVE_INIT) begin
      target <= tq;
      t <= tq;
    end else if (cmd.op == OP_STEP) begin
      if (tn < 0) t <= '0;
      else if (tn > 20'sd65536) t <= ONE_Q16;
      else t <= QW'(tn);
    end
  end

  // table memory and evaluation
  logic [QW-1:0] xs, rd, t0, t1;
  logic [IW-1:0] eidx;
  logic [15:0] f;
  logic [27:0] pp;
  logic [AW-1:0] raddr, waddr;
  logic [QW-1:0] wdata;
  logic wen;
  logic [34:0] ip;

  assign xs = (x_in > ONE_Q16) ? ONE_Q16 : x_in;
  assign pp = 28'(xs) * 28'(DIV);

  always_comb begin
    wen = 1'b0; waddr = AW'(cmd.idx); wdata = '0;
    if (cmd.op == OP_WRITE_ENDS) begin
      wen = 1'b1;
      waddr = cmd.last_end ? AW'(DIV) : '0;
      wdata = cmd.last_end ? ONE_Q16 : '0;
    end else if (cmd.op == OP_WRITE_Y) begin
      wen = 1'b1;
      wdata = (sum > 19'(ONE_Q16)) ? ONE_Q16 : QW'(sum);
    end
    raddr = (cmd.op == OP_EVAL_RD0) ? AW'(pp >> 16)
          : AW'((eidx >= DIV_I) ? DIV_I : eidx + IW'(1));
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EVAL_RD0) begin
      eidx <= IW'(pp >> 16);
      f <= pp[15:0];
    end
    if (cmd.op == OP_EVAL_RD1) t0 <= rd;
    if (cmd.op == OP_EVAL_MUL) t1 <= rd;
  end

  // interpolate: t0 + (t1-t0)*f rounded
  logic signed [18:0] dlt;
  logic signed [36:0] ipn;
  assign dlt = $signed({2'b0, t1}) - $signed({2'b0, t0});
  assign ipn = $signed({4'b0, t0, 16'd0}) + $signed(dlt) * $signed({1'b0, f}) + 37'sd32768;
  assign ip = 35'(ipn >>> 16);

  logic [QW-1:0] yv;
  always_comb begin
    if (linear_mode) yv = xs;
    else if (eidx >= DIV_I) yv = t0;
    else if (ip > 35'(ONE_Q16)) yv = ONE_Q16;
    else yv = QW'(ip);
  end
  always_ff @(posedge clk) y_out <= yv;
endmodule

[rtl/bezier_easing_table.sv]
// Cubic Bezier easing curve held in a lookup table.
// Command channel: start/busy with kind and x_in. kind=0 rebuilds the table
// from the control-point registers and gives no result; kind=1 evaluates.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index 0..3 selects
// ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2; writes beyond that are dropped.
// Result: y_out valid for one cycle with strobe; the receiver cannot stall.
// Evaluate: in linear mode y_out is registered from x_in clamped to 1.0; otherwise
// two registered table reads, then the interpolation multiply.
// Throughput: a command every cycle in linear mode; otherwise busy holds off the next.
// Rebuild with linear points: no busy time. Otherwise three setup states, then
// per inner entry one init state, up to 33 solve iterations (a curve
// evaluation on the shared multiplier plus a check), one y evaluation and
// a write; busy stays high throughout.
// Reset: control points 20,20,107,107 and linear mode; the table contents
// are undefined until a non-linear rebuild fills them.
// Depends on bet_pkg, bet_ctrl, bet_dp.
module bezier_easing_table #(
  parameter int unsigned TABLE_DIVISIONS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [16:0] x_in,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        strobe,
  output logic [16:0] y_out
);
  import bet_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DIVISIONS + 1) + 1;

  logic [6:0] x1, y1, x2, y2;
  logic set_linear, clr_linear, linear_mode;
  dp_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // control point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= 7'd20; y1 <= 7'd20; x2 <= 7'd107; y2 <= 7'd107;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X1: x1 <= cfg_data;
        REG_Y1: y1 <= cfg_data;
        REG_X2: x2 <= cfg_data;
        REG_Y2: y2 <= cfg_data;
        default: ;
      endcase
    end
  end

  bet_ctrl #(.DIV(TABLE_DIVISIONS), .IW(IW)) u_ctrl (
    .clk, .rst, .start, .kind,
    .is_linear_pts((x1 == y1) && (x2 == y2)),
    .stat, .busy, .set_linear, .clr_linear, .linear_mode, .cmd, .strobe
  );

  bet_dp #(.DIV(TABLE_DIVISIONS), .IW(IW)) u_dp (
    .clk, .rst, .cmd, .x1, .y1, .x2, .y2, .x_in, .linear_mode, .stat, .y_out
  );
endmodule
